[hdl/tds_pkg.sv]
// ---------------------------------------------------------------------------
// tds_pkg: shared types and codes for the task dependency scheduler
// Request and result codes, error codes, and the queue entry that carries
// an accepted request from the front end to the back end.
// ---------------------------------------------------------------------------
package tds_pkg;

   localparam int DEF_MAX_TASKS      = 32;
   localparam int DEF_MAX_SUCCESSORS = 8;
   localparam int ID_W               = 5;
   localparam int TASK_LIMIT         = 32;
   localparam int RESULT_CAP         = 32;

   typedef enum logic [2:0] {
      REQ_ADD    = 3'd0,
      REQ_EDGE   = 3'd1,
      REQ_SUBMIT = 3'd2,
      REQ_DONE   = 3'd3,
      REQ_RESET  = 3'd4
   } req_code_type;

   typedef enum logic [2:0] {
      KIND_ID    = 3'd0,
      KIND_ACK   = 3'd1,
      KIND_DISP  = 3'd2,
      KIND_ALL   = 3'd3,
      KIND_RESET = 3'd4,
      KIND_ERR   = 3'd5
   } kind_code_type;

   typedef enum logic [2:0] {
      ERR_NONE  = 3'd0,
      ERR_FULL  = 3'd1,
      ERR_PRED  = 3'd2,
      ERR_LIST  = 3'd3,
      ERR_BUSY  = 3'd4
   } err_code_type;

   // request word held in the queue
   typedef struct packed {
      logic [2:0]      req_type;
      logic [ID_W-1:0] done_task;
      logic [ID_W-1:0] pred_task;
   } req_word_type;

   // result word
   typedef struct packed {
      logic [2:0]      kind;
      logic [ID_W-1:0] task_id;
      logic [2:0]      err;
      logic            last;
   } rsp_word_type;

endpackage

[hdl/task_dependency_scheduler_top.sv]
// ---------------------------------------------------------------------------
// task_dependency_scheduler_top: task graph dependency tracker
// Add, edge, reset and invalid requests give one word each; the request is
// registered into the queue and the result word into the output register,
// and such requests run one per cycle while results are not stalled. Submit
// keeps the execution unit busy while it scans the added tasks. Completion
// reads each successor entry of the done task, and a dispatch followed by
// all done takes one more state; every stalled result word holds the
// sequencer until it is taken. A two-word queue lets requests be taken while
// the execution unit is busy.
// ---------------------------------------------------------------------------
module task_dependency_scheduler_top
   import tds_pkg::*;
#(
   parameter int MAX_TASKS      = DEF_MAX_TASKS,
   parameter int MAX_SUCCESSORS = DEF_MAX_SUCCESSORS
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [2:0]  req_req_type,
   input  logic [4:0]  req_done_task,
   input  logic [4:0]  req_pred_task,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [2:0]  rsp_result_kind,
   output logic [4:0]  rsp_out_task,
   output logic [2:0]  rsp_error_code,
   output logic        rsp_last
);

   req_word_type in_word, q_word;
   rsp_word_type out_word;
   logic         q_valid, q_pop;

   assign in_word.req_type  = req_req_type;
   assign in_word.done_task = req_done_task;
   assign in_word.pred_task = req_pred_task;

   // intake queue
   tds_front u_front (
      .clock, .reset, .req_valid, .req_stall, .req_word(in_word),
      .q_valid, .q_pop, .q_word
   );

   // execution
   tds_back #(.MAX_TASKS(MAX_TASKS), .MAX_SUCCESSORS(MAX_SUCCESSORS)) u_back (
      .clock, .reset, .q_valid, .q_pop, .q_word,
      .rsp_valid, .rsp_stall, .rsp_word(out_word)
   );

   assign rsp_result_kind = out_word.kind;
   assign rsp_out_task    = out_word.task_id;
   assign rsp_error_code  = out_word.err;
   assign rsp_last        = out_word.last;

endmodule

[hdl/tds_front.sv]
// ---------------------------------------------------------------------------
// tds_front: request intake
// Registers each accepted request word into a small two-entry queue so the
// back end can stall on its own while intake keeps flowing.
// ---------------------------------------------------------------------------
module tds_front
   import tds_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_stall,
   input  req_word_type req_word,
   output logic         q_valid,
   input  logic         q_pop,
   output req_word_type q_word
);

   req_word_type slot_ff [2];
   req_word_type slot_in [2];
   logic [1:0]   cnt_ff, cnt_in;
   logic         push;

   assign req_stall = (cnt_ff == 2'd2);
   assign push      = req_valid && !req_stall;
   assign q_valid   = (cnt_ff != 2'd0);
   assign q_word    = slot_ff[0];

   // queue shift and fill
   always_comb begin
      logic pop;
      pop = q_pop && q_valid;
      slot_in[0] = slot_ff[0];
      slot_in[1] = slot_ff[1];
      cnt_in     = cnt_ff;
      if (pop) begin
         slot_in[0] = slot_ff[1];
         cnt_in     = cnt_in - 2'd1;
      end
      if (push) begin
         slot_in[cnt_in[0]] = req_word;
         cnt_in = cnt_in + 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else begin
         cnt_ff <= cnt_in;
      end
      slot_ff[0] <= slot_in[0];
      slot_ff[1] <= slot_in[1];
   end

endmodule

[hdl/tds_back.sv]
// ---------------------------------------------------------------------------
// tds_back: request execution
// Sequencer that checks a request against the task table, walks the task
// list on submit and the successor memory on completion, and emits results.
// ---------------------------------------------------------------------------
module tds_back
   import tds_pkg::*;
#(
   parameter int MAX_TASKS      = DEF_MAX_TASKS,
   parameter int MAX_SUCCESSORS = DEF_MAX_SUCCESSORS
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         q_valid,
   output logic         q_pop,
   input  req_word_type q_word,
   output logic         rsp_valid,
   input  logic         rsp_stall,
   output rsp_word_type rsp_word
);

   localparam int TW  = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
   localparam int CAP = (MAX_TASKS > TASK_LIMIT) ? TASK_LIMIT : MAX_TASKS;
   localparam int CW  = $clog2(MAX_SUCCESSORS + 1);
   localparam int NW  = $clog2(TASK_LIMIT + 1);
   localparam int DEPTH = MAX_TASKS * MAX_SUCCESSORS;
   localparam int AW  = $clog2(DEPTH);

   typedef enum logic [2:0] {
      S_IDLE, S_SCAN, S_READ, S_WALK, S_FIN, S_OUT
   } state_type;

   state_type         state_ff;
   logic [ID_W-1:0]   pend_ff  [MAX_TASKS];
   logic [CW-1:0]     scnt_ff  [MAX_TASKS];
   logic [NW-1:0]     added_ff, outst_ff;
   logic              subm_ff;
   logic [NW-1:0]     idx_ff;
   logic [CW-1:0]     k_ff;
   logic [CW-1:0]     kmax_ff;
   logic [TW-1:0]     done_ff;
   logic [5:0]        n_ff;
   logic              hold_v_ff;   // newest dispatch of a walk, not yet shown
   logic [ID_W-1:0]   hold_id_ff;
   rsp_word_type      out_ff;
   logic              ov_ff;

   // successor memory, registered read
   logic [ID_W-1:0]   succ_mem [DEPTH];
   logic [ID_W-1:0]   rd_ff;
   logic              we;
   logic [AW-1:0]     waddr, raddr;
   logic [ID_W-1:0]   wdata;

   always_ff @(posedge clock) begin
      if (we) succ_mem[waddr] <= wdata;
      rd_ff <= succ_mem[raddr];
   end

   req_word_type     w;
   logic [NW-1:0]    newest;
   logic [TW-1:0]    pred_i, new_i;
   logic             out_free;
   logic             fin_all;

   assign w        = q_word;
   assign newest   = added_ff - NW'(1);
   assign pred_i   = TW'(w.pred_task);
   assign new_i    = TW'(newest);
   assign out_free = !ov_ff || !rsp_stall;
   assign rsp_valid = ov_ff;
   assign rsp_word  = out_ff;
   assign q_pop     = (state_ff == S_IDLE) && q_valid && out_free;
   assign fin_all   = (outst_ff == NW'(1)) && (n_ff < 6'(RESULT_CAP));

   assign waddr = AW'(pred_i * MAX_SUCCESSORS) + AW'(scnt_ff[pred_i]);
   assign wdata = ID_W'(newest);
   assign we    = q_pop && (w.req_type == REQ_EDGE) && !subm_ff && added_ff != 0
                  && NW'(w.pred_task) < newest
                  && scnt_ff[pred_i] < CW'(MAX_SUCCESSORS)
                  && pend_ff[new_i] < ID_W'(31);
   assign raddr = AW'(done_ff * MAX_SUCCESSORS) + AW'(k_ff);

   // one result at a time into the output register
   function automatic rsp_word_type mk(input logic [2:0] k, input logic [ID_W-1:0] t,
                                       input logic [2:0] e, input logic l);
      rsp_word_type r;
      r.kind = k; r.task_id = t; r.err = e; r.last = l;
      return r;
   endfunction

   // any later zero-pending task in the added range
   function automatic logic [0:0] lookahead(input logic [NW-1:0] from);
      logic r;
      r = 1'b0;
      for (int i = 0; i < MAX_TASKS; i++)
         if (NW'(i) >= from && NW'(i) < added_ff && pend_ff[i] == 0) r = 1'b1;
      return r;
   endfunction

   logic [ID_W-1:0] s_id;
   logic [TW-1:0]   s_i;
   assign s_id = rd_ff;
   assign s_i  = TW'(rd_ff);

   // sequencer and table state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_IDLE;
         ov_ff     <= 1'b0;
         added_ff  <= '0;
         outst_ff  <= '0;
         subm_ff   <= 1'b0;
         hold_v_ff <= 1'b0;
         for (int i = 0; i < MAX_TASKS; i++) begin
            pend_ff[i] <= '0;
            scnt_ff[i] <= '0;
         end
      end else begin
         if (ov_ff && !rsp_stall) ov_ff <= 1'b0;
         unique case (state_ff)
            S_IDLE: begin
               if (q_pop) begin
                  ov_ff <= 1'b1;
                  n_ff  <= '0;
                  unique case (w.req_type)
                     REQ_ADD: begin
                        if (subm_ff) out_ff <= mk(KIND_ERR, '0, ERR_BUSY, 1'b1);
                        else if (added_ff >= NW'(CAP))
                           out_ff <= mk(KIND_ERR, '0, ERR_FULL, 1'b1);
                        else begin
                           pend_ff[TW'(added_ff)] <= '0;
                           scnt_ff[TW'(added_ff)] <= '0;
                           added_ff <= added_ff + NW'(1);
                           out_ff <= mk(KIND_ID, ID_W'(added_ff), ERR_NONE, 1'b1);
                        end
                     end
                     REQ_EDGE: begin
                        if (subm_ff) out_ff <= mk(KIND_ERR, '0, ERR_BUSY, 1'b1);
                        else if (added_ff == 0 || NW'(w.pred_task) >= newest)
                           out_ff <= mk(KIND_ERR, '0, ERR_PRED, 1'b1);
                        else if (!we) out_ff <= mk(KIND_ERR, '0, ERR_LIST, 1'b1);
                        else begin
                           scnt_ff[pred_i] <= scnt_ff[pred_i] + CW'(1);
                           pend_ff[new_i]  <= pend_ff[new_i] + ID_W'(1);
                           out_ff <= mk(KIND_ACK, '0, ERR_NONE, 1'b1);
                        end
                     end
                     REQ_SUBMIT: begin
                        if (subm_ff) out_ff <= mk(KIND_ERR, '0, ERR_BUSY, 1'b1);
                        else begin
                           subm_ff  <= 1'b1;
                           outst_ff <= added_ff;
                           if (added_ff == 0) out_ff <= mk(KIND_ALL, '0, ERR_NONE, 1'b1);
                           else begin
                              ov_ff    <= 1'b0;
                              idx_ff   <= '0;
                              state_ff <= S_SCAN;
                           end
                        end
                     end
                     REQ_DONE: begin
                        if (!subm_ff || outst_ff == 0)
                           out_ff <= mk(KIND_ERR, '0, ERR_BUSY, 1'b1);
                        else if (NW'(w.done_task) >= added_ff)
                           out_ff <= mk(KIND_ERR, '0, ERR_PRED, 1'b1);
                        else begin
                           ov_ff     <= 1'b0;
                           hold_v_ff <= 1'b0;
                           done_ff   <= TW'(w.done_task);
                           kmax_ff   <= scnt_ff[TW'(w.done_task)];
                           k_ff      <= '0;
                           state_ff  <= S_READ;
                        end
                     end
                     REQ_RESET: begin
                        if (subm_ff && outst_ff != 0)
                           out_ff <= mk(KIND_ERR, '0, ERR_BUSY, 1'b1);
                        else begin
                           added_ff <= '0;
                           outst_ff <= '0;
                           subm_ff  <= 1'b0;
                           for (int i = 0; i < MAX_TASKS; i++) begin
                              pend_ff[i] <= '0;
                              scnt_ff[i] <= '0;
                           end
                           out_ff <= mk(KIND_RESET, '0, ERR_NONE, 1'b1);
                        end
                     end
                     default: out_ff <= mk(KIND_ACK, '0, ERR_NONE, 1'b1);
                  endcase
               end
            end
            // submit: one task per cycle while results are not stalled; last comes from a lookahead
            S_SCAN: begin
               if (out_free) begin
                  if (idx_ff < added_ff && n_ff < 6'(RESULT_CAP)) begin
                     if (pend_ff[TW'(idx_ff)] == 0) begin
                        ov_ff  <= 1'b1;
                        out_ff <= mk(KIND_DISP, ID_W'(idx_ff), ERR_NONE,
                                     !(idx_ff + NW'(1) < added_ff
                                       && n_ff + 6'd1 < 6'(RESULT_CAP)
                                       && |lookahead(idx_ff + NW'(1))));
                        n_ff   <= n_ff + 6'd1;
                     end
                     idx_ff <= idx_ff + NW'(1);
                  end else begin
                     state_ff <= S_IDLE;
                  end
               end
            end
            // completion: read one successor entry
            S_READ: begin
               if (k_ff < kmax_ff) state_ff <= S_WALK;
               else                state_ff <= S_FIN;
            end
            // a new dispatch pushes out the one held before it, marked not last
            S_WALK: begin
               if (out_free) begin
                  k_ff     <= k_ff + CW'(1);
                  state_ff <= S_READ;
                  if (NW'(s_id) < added_ff && pend_ff[s_i] != 0) begin
                     pend_ff[s_i] <= pend_ff[s_i] - ID_W'(1);
                     if (pend_ff[s_i] == ID_W'(1) && n_ff < 6'(RESULT_CAP)) begin
                        n_ff       <= n_ff + 6'd1;
                        hold_v_ff  <= 1'b1;
                        hold_id_ff <= s_id;
                        if (hold_v_ff) begin
                           ov_ff  <= 1'b1;
                           out_ff <= mk(KIND_DISP, hold_id_ff, ERR_NONE, 1'b0);
                        end
                     end
                  end
               end
            end
            // completion tail: held dispatch, then all done if it was the last task; else all done or a lone ack
            S_FIN: begin
               if (out_free) begin
                  outst_ff <= outst_ff - NW'(1);
                  ov_ff    <= 1'b1;
                  if (hold_v_ff) begin
                     hold_v_ff <= 1'b0;
                     out_ff    <= mk(KIND_DISP, hold_id_ff, ERR_NONE, !fin_all);
                     state_ff  <= fin_all ? S_OUT : S_IDLE;
                  end else begin
                     state_ff <= S_IDLE;
                     if (fin_all) out_ff <= mk(KIND_ALL, '0, ERR_NONE, 1'b1);
                     else         out_ff <= mk(KIND_ACK, '0, ERR_NONE, 1'b1);
                  end
               end
            end
            S_OUT: begin
               if (out_free) begin
                  ov_ff    <= 1'b1;
                  out_ff   <= mk(KIND_ALL, '0, ERR_NONE, 1'b1);
                  state_ff <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

endmodule

[hdl/tds_checker.sv]
// ---------------------------------------------------------------------------
// tds_checker: port checks for the scheduler
// Watches the result channel for handshake and encoding rules.
// ---------------------------------------------------------------------------
module tds_checker
   import tds_pkg::*;
(
   input logic       clock,
   input logic       reset,
   input logic       rsp_valid,
   input logic       rsp_stall,
   input logic [2:0] rsp_result_kind,
   input logic [4:0] rsp_out_task,
   input logic [2:0] rsp_error_code,
   input logic       rsp_last
);

   // stalled word holds its kind and task
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_result_kind)
      && $stable(rsp_out_task))
      else $error("result word changed under stall");

   // error code only with error kind
   a_err: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_result_kind != KIND_ERR |-> rsp_error_code == ERR_NONE)
      else $error("error code without error kind");

   // task id only on id and dispatch
   a_task: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_result_kind != KIND_ID && rsp_result_kind != KIND_DISP
      |-> rsp_out_task == '0)
      else $error("task id on wrong kind");

   // error, reset and all-done words end their sequence
   a_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_result_kind == KIND_ERR || rsp_result_kind == KIND_RESET
      || rsp_result_kind == KIND_ALL) |-> rsp_last)
      else $error("single result not marked last");

endmodule

bind task_dependency_scheduler_top tds_checker u_tds_checker (.*);
